// ----- hw/rtl/b2da_pkg.sv -----
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int DIGIT_WIDTH = 4;
    localparam int CHAR_WIDTH  = 6;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

    typedef logic [DIGIT_WIDTH-1:0] digit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic convert;
        logic advance;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/b2da_cell.sv -----
`timescale 1ns / 1ps

module b2da_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b2da_pkg::cell_ctrl_t ctrl,
    input  logic                 carry_in,
    input  b2da_pkg::digit_t     digit_in,
    output logic                 carry_out,
    output b2da_pkg::digit_t     digit
);

    b2da_pkg::digit_t digit_reg;
    b2da_pkg::digit_t digit_next;
    b2da_pkg::digit_t adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    end

    assign carry_out = adj[3];

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.convert)
        begin
            digit_next = {adj[2:0], carry_in};
        end
        else if (ctrl.advance)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

// ----- hw/rtl/binary_to_decimal_ascii_top.sv -----
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------
// input    | in        | in_valid / in_ready  | value[63:0]
// output   | out       | out_valid / out_ready| digit_char[5:0], last_digit
//
// One number passes through the accept cycle, one bit per cycle through the row of
// BCD digit cells, and one digit per cycle out of the top cell while the output
// does not stall, with leading zeros dropped before emission. Output stalls hold
// the digit row.
// A new transaction is taken once the last digit sits in the output register.
// Reset clears all control state.

module binary_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  digit_char,
    output logic        last_digit
);

    localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BitCntW   = $clog2(VALUE_WIDTH + 1);
    localparam int DigCntW   = $clog2(NumDigits + 1);

    b2da_pkg::state_t     state_reg;
    b2da_pkg::state_t     state_next;
    b2da_pkg::cell_ctrl_t ctrl;

    logic [VALUE_WIDTH-1:0] val_reg;
    logic [BitCntW-1:0]     bit_cnt_reg;
    logic [DigCntW-1:0]     dig_cnt_reg;
    logic                   out_valid_reg;
    logic [5:0]             digit_char_reg;
    logic                   last_digit_reg;

    logic             accept;
    logic             out_free;
    logic             emit;
    logic             top_zero;
    logic             on_last;
    b2da_pkg::digit_t top_digit;

    logic             carry [NumDigits+1];
    b2da_pkg::digit_t digits [NumDigits];

    assign carry[0] = val_reg[VALUE_WIDTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < NumDigits; gi++)
        begin : g_cell
            b2da_pkg::digit_t lower;
            if (gi == 0)
            begin : g_first
                assign lower = '0;
            end
            else
            begin : g_rest
                assign lower = digits[gi-1];
            end
            b2da_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .carry_in  (carry[gi]),
                .digit_in  (lower),
                .carry_out (carry[gi+1]),
                .digit     (digits[gi])
            );
        end
    endgenerate

    assign top_digit = digits[NumDigits-1];
    assign top_zero  = (top_digit == '0);
    assign on_last   = (dig_cnt_reg == DigCntW'(1));
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == b2da_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            b2da_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = b2da_pkg::ST_CONV;
                end
            end
            b2da_pkg::ST_CONV:
            begin
                if (bit_cnt_reg == BitCntW'(1))
                begin
                    state_next = b2da_pkg::ST_SKIP;
                end
            end
            b2da_pkg::ST_SKIP:
            begin
                if (!top_zero || on_last)
                begin
                    state_next = b2da_pkg::ST_EMIT;
                end
            end
            b2da_pkg::ST_EMIT:
            begin
                if (out_free && on_last)
                begin
                    state_next = b2da_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = b2da_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        emit = 1'b0;
        unique case (state_reg)
            b2da_pkg::ST_IDLE:
            begin
                ctrl.clear = in_valid;
            end
            b2da_pkg::ST_CONV:
            begin
                ctrl.convert = 1'b1;
            end
            b2da_pkg::ST_SKIP:
            begin
                ctrl.advance = top_zero && !on_last;
            end
            b2da_pkg::ST_EMIT:
            begin
                ctrl.advance = out_free;
                emit         = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= b2da_pkg::ST_IDLE;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                bit_cnt_reg <= BitCntW'(VALUE_WIDTH);
                dig_cnt_reg <= DigCntW'(NumDigits);
            end
            else
            begin
                if (ctrl.convert)
                begin
                    bit_cnt_reg <= bit_cnt_reg - BitCntW'(1);
                end
                if (ctrl.advance)
                begin
                    dig_cnt_reg <= dig_cnt_reg - DigCntW'(1);
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg <= value[VALUE_WIDTH-1:0];
        end
        else if (ctrl.convert)
        begin
            val_reg <= val_reg << 1;
        end
        if (emit)
        begin
            digit_char_reg <= b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
            last_digit_reg <= on_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last_digit = last_digit_reg;

endmodule
